### sv/cmrd_pkg.sv
// Shared types, constants and frame decode for the motor CAN reply decoder.
package cmrd_pkg;

  // Motor count limits and default
  localparam int MAX_MOTORS     = 8;
  localparam int DEF_NUM_MOTORS = 8;

  // Frame fields
  localparam logic [3:0]  FRAME_LEN_FULL = 4'd8;
  localparam logic [10:0] ID_MOTOR_BASE  = 11'h581;
  localparam logic [10:0] ID_TEMP        = 11'h589;
  localparam logic [7:0]  LEAD_STATUS    = 8'h2B;
  localparam logic [7:0]  LEAD_DATA      = 8'h23;

  // Status reply codes in byte 4
  localparam logic [7:0] ST_FAULT_CODE  = 8'h80;
  localparam logic [7:0] ST_STOP_CODE   = 8'h0E;
  localparam logic [7:0] ST_START_CODE  = 8'h07;
  localparam logic [7:0] ST_ENABLE_CODE = 8'h0F;

  // Data reply subcodes in byte 3
  localparam logic [7:0] SUB_ACK = 8'h00;
  localparam logic [7:0] SUB_FWD = 8'h03;
  localparam logic [7:0] SUB_REV = 8'h05;

  // Stored motor status codes
  localparam logic [1:0] MST_STOPPED = 2'd0;
  localparam logic [1:0] MST_ENABLED = 2'd1;
  localparam logic [1:0] MST_STARTED = 2'd2;
  localparam logic [1:0] MST_FAULT   = 2'd3;

  typedef enum logic [1:0] {
    KIND_IGNORED = 2'd0,
    KIND_TEMP    = 2'd1,
    KIND_STATUS  = 2'd2,
    KIND_DATA    = 2'd3
  } cmrd_kind_t;

  // Decoded control for one frame
  typedef struct packed {
    cmrd_kind_t  kind;
    logic [2:0]  idx;
    logic        upd_temp;
    logic        upd_status;
    logic [1:0]  status_code;
    logic        set_ready;
    logic        upd_motion;
    logic        reverse;
  } cmrd_dec_t;

  // Classify a frame and work out which state it touches
  function automatic cmrd_dec_t cmrd_decode(input logic [3:0]  len,
                                            input logic [10:0] id,
                                            input logic [7:0]  b0,
                                            input logic [7:0]  b3,
                                            input logic [7:0]  b4,
                                            input int          num);
    cmrd_dec_t   d;
    logic [10:0] off;
    d   = '0;
    off = id - ID_MOTOR_BASE;
    if (len == FRAME_LEN_FULL) begin
      if (id == ID_TEMP) begin
        d.kind     = KIND_TEMP;
        d.upd_temp = 1'b1;
      end else if (id >= ID_MOTOR_BASE && 32'(off) < num) begin
        d.idx = off[2:0];
        if (b0 == LEAD_STATUS) begin
          d.kind = KIND_STATUS;
          case (b4)
            ST_FAULT_CODE: begin
              d.upd_status  = 1'b1;
              d.status_code = MST_FAULT;
            end
            ST_STOP_CODE: begin
              d.upd_status  = 1'b1;
              d.status_code = MST_STOPPED;
            end
            ST_START_CODE: begin
              d.upd_status  = 1'b1;
              d.status_code = MST_STARTED;
            end
            ST_ENABLE_CODE: begin
              d.upd_status  = 1'b1;
              d.status_code = MST_ENABLED;
            end
            default: begin
              d.upd_status = 1'b0;
            end
          endcase
        end else if (b0 == LEAD_DATA) begin
          d.kind = KIND_DATA;
          if (b3 == SUB_ACK) begin
            d.set_ready = 1'b1;
          end else if (b3 == SUB_FWD || b3 == SUB_REV) begin
            d.set_ready  = 1'b1;
            d.upd_motion = 1'b1;
            d.reverse    = (b3 == SUB_REV);
          end
        end
      end
    end
    return d;
  endfunction

endpackage

### sv/cmrd_bcd.sv
// Four-digit BCD word to binary hundredths; nibbles above nine keep their raw weight.
module cmrd_bcd (
  input  logic [15:0] bcd_word,
  output logic [14:0] value
);

  logic [3:0] d3, d2, d1, d0;

  // Split digits and weight them
  assign d3 = bcd_word[15:12];
  assign d2 = bcd_word[11:8];
  assign d1 = bcd_word[7:4];
  assign d0 = bcd_word[3:0];

  assign value = 15'(d3) * 15'd1000 + 15'(d2) * 15'd100
               + 15'(d1) * 15'd10 + 15'(d0);

endmodule

### sv/cmrd_motor_state.sv
// Per-motor status, speed and current stores plus the sticky ready mask.
module cmrd_motor_state #(
  parameter int NUM_MOTORS = cmrd_pkg::DEF_NUM_MOTORS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               commit,
  input  cmrd_pkg::cmrd_dec_t dec,
  input  logic [15:0]        speed_raw,
  input  logic [15:0]        current_raw,
  output logic [2:0]         motor_index,
  output logic signed [2:0]  motor_status,
  output logic signed [15:0] motor_speed,
  output logic signed [15:0] motor_current,
  output logic [7:0]         ready_mask
);
  import cmrd_pkg::*;

  localparam int IDXW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  logic [1:0]            status_r  [NUM_MOTORS];
  logic [15:0]           speed_r   [NUM_MOTORS];
  logic [15:0]           current_r [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] ready_r;
  logic [NUM_MOTORS-1:0] ready_nxt;

  logic [IDXW-1:0] sel;
  logic [15:0]     speed_in;
  logic [1:0]      status_post;
  logic [15:0]     speed_post;
  logic [15:0]     current_post;
  logic            is_motor;

  assign sel      = dec.idx[IDXW-1:0];
  assign is_motor = (dec.kind == KIND_STATUS) || (dec.kind == KIND_DATA);

  // Negate for reverse; wraps at the most negative value
  assign speed_in = dec.reverse ? 16'(~speed_raw + 16'd1) : speed_raw;

  // Values of the addressed motor after this frame
  always_comb begin
    status_post  = dec.upd_status ? dec.status_code : status_r[sel];
    speed_post   = dec.upd_motion ? speed_in : speed_r[sel];
    current_post = dec.upd_motion ? current_raw : current_r[sel];
    ready_nxt    = ready_r;
    if (dec.set_ready) begin
      ready_nxt = ready_r | (NUM_MOTORS'(1) << sel);
    end
  end

  // Commit the update when the frame moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        status_r[i]  <= MST_STOPPED;
        speed_r[i]   <= '0;
        current_r[i] <= '0;
      end
      ready_r <= '0;
    end else if (commit) begin
      if (dec.upd_status) begin
        status_r[sel] <= dec.status_code;
      end
      if (dec.upd_motion) begin
        speed_r[sel]   <= speed_in;
        current_r[sel] <= current_raw;
      end
      ready_r <= ready_nxt;
    end
  end

  // Zero motor fields on non-motor results
  assign motor_index   = is_motor ? dec.idx : 3'd0;
  assign motor_status  = is_motor ? {&status_post, status_post} : 3'sd0;
  assign motor_speed   = is_motor ? speed_post : 16'sd0;
  assign motor_current = is_motor ? current_post : 16'sd0;
  assign ready_mask    = 8'(ready_nxt);

endmodule

### sv/motor_can_reply_decoder.sv
// Motor CAN reply decoder: input register, decode and state update, result register.
// The input register feeds the result register directly; an accepted beat passes both.
// Throughput: one frame per cycle while the result is not stalled.
// A stalled result holds the input register, which then stalls the input channel.
// Reset (rst_n low, synchronous) clears both valid flags, all motor stores,
// the ready mask and both temperatures to zero.
module motor_can_reply_decoder #(
  parameter int NUM_MOTORS = cmrd_pkg::DEF_NUM_MOTORS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_frame_len,
  input  logic [10:0]        in_can_id,
  input  logic [7:0]         in_byte0,
  input  logic [7:0]         in_byte1,
  input  logic [7:0]         in_byte2,
  input  logic [7:0]         in_byte3,
  input  logic [7:0]         in_byte4,
  input  logic [7:0]         in_byte5,
  input  logic [7:0]         in_byte6,
  input  logic [7:0]         in_byte7,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_result_kind,
  output logic [2:0]         out_motor_index,
  output logic signed [2:0]  out_motor_status,
  output logic signed [15:0] out_motor_speed,
  output logic signed [15:0] out_motor_current,
  output logic [7:0]         out_ready_mask,
  output logic [14:0]        out_cabin_temp,
  output logic [14:0]        out_wall_temp
);
  import cmrd_pkg::*;

  // Input register
  logic        in_vld_r;
  logic [3:0]  len_r;
  logic [10:0] id_r;
  logic [7:0]  b0_r, b3_r, b4_r, b5_r, b6_r, b7_r;

  // Result register
  logic               out_vld_r;
  logic [1:0]         kind_r;
  logic [2:0]         index_r;
  logic signed [2:0]  status_r;
  logic signed [15:0] speed_r;
  logic signed [15:0] current_r;
  logic [7:0]         ready_r;
  logic [14:0]        cabin_out_r;
  logic [14:0]        wall_out_r;

  // Temperature state
  logic [14:0] cabin_r, cabin_nxt;
  logic [14:0] wall_r, wall_nxt;
  logic [14:0] cabin_bin, wall_bin;

  logic               adv;
  logic               in_take;
  cmrd_dec_t          dec;
  logic [2:0]         m_index;
  logic signed [2:0]  m_status;
  logic signed [15:0] m_speed;
  logic signed [15:0] m_current;
  logic [7:0]         m_ready;

  // Handshake: advance when the result register is free or draining
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      len_r <= in_frame_len;
      id_r  <= in_can_id;
      b0_r  <= in_byte0;
      b3_r  <= in_byte3;
      b4_r  <= in_byte4;
      b5_r  <= in_byte5;
      b6_r  <= in_byte6;
      b7_r  <= in_byte7;
    end
  end

  // Decode the held frame; bytes 1 and 2 carry nothing used
  assign dec = cmrd_decode(len_r, id_r, b0_r, b3_r, b4_r, NUM_MOTORS);

  cmrd_bcd u_bcd_cabin (
    .bcd_word ({b5_r, b4_r}),
    .value    (cabin_bin)
  );

  cmrd_bcd u_bcd_wall (
    .bcd_word ({b7_r, b6_r}),
    .value    (wall_bin)
  );

  assign cabin_nxt = dec.upd_temp ? cabin_bin : cabin_r;
  assign wall_nxt  = dec.upd_temp ? wall_bin : wall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cabin_r <= '0;
      wall_r  <= '0;
    end else if (adv) begin
      cabin_r <= cabin_nxt;
      wall_r  <= wall_nxt;
    end
  end

  cmrd_motor_state #(
    .NUM_MOTORS (NUM_MOTORS)
  ) u_motor_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .commit        (adv),
    .dec           (dec),
    .speed_raw     ({b5_r, b4_r}),
    .current_raw   ({b7_r, b6_r}),
    .motor_index   (m_index),
    .motor_status  (m_status),
    .motor_speed   (m_speed),
    .motor_current (m_current),
    .ready_mask    (m_ready)
  );

  // Result valid: set on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r      <= dec.kind;
      index_r     <= m_index;
      status_r    <= m_status;
      speed_r     <= m_speed;
      current_r   <= m_current;
      ready_r     <= m_ready;
      cabin_out_r <= cabin_nxt;
      wall_out_r  <= wall_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_result_kind   = kind_r;
  assign out_motor_index   = index_r;
  assign out_motor_status  = status_r;
  assign out_motor_speed   = speed_r;
  assign out_motor_current = current_r;
  assign out_ready_mask    = ready_r;
  assign out_cabin_temp    = cabin_out_r;
  assign out_wall_temp     = wall_out_r;

  // Non-motor results carry zero motor fields
  a_nonmotor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_IGNORED || out_result_kind == KIND_TEMP) |->
      out_motor_index == 3'd0 && out_motor_status == 3'sd0 &&
      out_motor_speed == 16'sd0 && out_motor_current == 16'sd0)
    else $error("motor fields not zero on non-motor result");

  // Ready bits only exist for configured motors
  a_ready_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ready_mask >> NUM_MOTORS) == 8'd0)
    else $error("ready bit set beyond motor count");

  // Input stalls only while a frame is held and cannot advance
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("input stalled without a blocked result");

  // A held frame that cannot move leaves the temperatures alone
  a_temp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cabin_r) && $stable(wall_r))
    else $error("temperature changed without an advance");

endmodule

### tb/motor_can_reply_decoder_check.sv
// Reply checker for the motor CAN reply decoder: predicts each reply beat and compares it.
`timescale 1ns / 100ps

module motor_can_reply_decoder_check #(
  parameter int NUM_MOTORS = cmrd_pkg::DEF_NUM_MOTORS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_frame_len,
  input  logic [10:0]        in_can_id,
  input  logic [7:0]         in_byte0,
  input  logic [7:0]         in_byte1,
  input  logic [7:0]         in_byte2,
  input  logic [7:0]         in_byte3,
  input  logic [7:0]         in_byte4,
  input  logic [7:0]         in_byte5,
  input  logic [7:0]         in_byte6,
  input  logic [7:0]         in_byte7,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_result_kind,
  input  logic [2:0]         out_motor_index,
  input  logic signed [2:0]  out_motor_status,
  input  logic signed [15:0] out_motor_speed,
  input  logic signed [15:0] out_motor_current,
  input  logic [7:0]         out_ready_mask,
  input  logic [14:0]        out_cabin_temp,
  input  logic [14:0]        out_wall_temp,
  output int                 mismatches,
  output int                 pending,
  output int                 n_ignored,
  output int                 n_temp,
  output int                 n_status,
  output int                 n_data
);
  import cmrd_pkg::*;

  typedef struct packed {
    cmrd_kind_t         kind;
    logic [2:0]         idx;
    logic signed [2:0]  status;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         ready;
    logic [14:0]        cabin;
    logic [14:0]        wall;
  } reply_t;

  // Shadow of the decoder state
  logic [1:0]  motor_state [MAX_MOTORS];
  logic [15:0] motor_speed [MAX_MOTORS];
  logic [15:0] motor_amps  [MAX_MOTORS];
  logic [7:0]  ready_seen;
  logic [14:0] cabin_hundredths;
  logic [14:0] wall_hundredths;

  reply_t replies_due [$];

  // Weight each nibble of a BCD word as it stands, digits above 9 included
  function automatic logic [14:0] bcd_hundredths(input logic [15:0] w);
    int v;
    v = w[15:12] * 1000 + w[11:8] * 100 + w[7:4] * 10 + w[3:0];
    return v[14:0];
  endfunction

  function automatic logic signed [2:0] reported_status(input logic [1:0] code);
    case (code)
      MST_ENABLED: return 3'sd1;
      MST_STARTED: return 3'sd2;
      MST_FAULT:   return -3'sd1;
      default:     return 3'sd0;
    endcase
  endfunction

  // Apply one frame to the shadow state and build the reply it must produce
  function automatic reply_t decode_reply(input logic [3:0] len, input logic [10:0] id,
                                          input logic [7:0] b0, input logic [7:0] b3,
                                          input logic [7:0] b4, input logic [7:0] b5,
                                          input logic [7:0] b6, input logic [7:0] b7);
    reply_t      r;
    logic [10:0] offset;
    logic [2:0]  m;
    logic [15:0] spd;
    r      = '0;
    offset = id - ID_MOTOR_BASE;
    m      = offset[2:0];
    if (len == FRAME_LEN_FULL) begin
      if (id == ID_TEMP) begin
        cabin_hundredths = bcd_hundredths({b5, b4});
        wall_hundredths  = bcd_hundredths({b7, b6});
        r.kind = KIND_TEMP;
      end else if (id >= ID_MOTOR_BASE && offset < NUM_MOTORS) begin
        if (b0 == LEAD_STATUS) begin
          r.kind = KIND_STATUS;
          case (b4)
            ST_FAULT_CODE:  motor_state[m] = MST_FAULT;
            ST_STOP_CODE:   motor_state[m] = MST_STOPPED;
            ST_START_CODE:  motor_state[m] = MST_STARTED;
            ST_ENABLE_CODE: motor_state[m] = MST_ENABLED;
            default: ;
          endcase
        end else if (b0 == LEAD_DATA) begin
          r.kind = KIND_DATA;
          if (b3 == SUB_FWD || b3 == SUB_REV) begin
            spd = {b5, b4};
            if (b3 == SUB_REV) spd = -spd;
            motor_speed[m] = spd;
            motor_amps[m]  = {b7, b6};
          end
          if (b3 == SUB_ACK || b3 == SUB_FWD || b3 == SUB_REV) ready_seen[m] = 1'b1;
        end
      end
    end
    // Motor fields only for motor replies
    if (r.kind == KIND_STATUS || r.kind == KIND_DATA) begin
      r.idx     = m;
      r.status  = reported_status(motor_state[m]);
      r.speed   = motor_speed[m];
      r.current = motor_amps[m];
    end
    r.ready = ready_seen;
    r.cabin = cabin_hundredths;
    r.wall  = wall_hundredths;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      // Clear the shadow state with the block
      for (int i = 0; i < MAX_MOTORS; i++) begin
        motor_state[i] = MST_STOPPED;
        motor_speed[i] = '0;
        motor_amps[i]  = '0;
      end
      ready_seen       = '0;
      cabin_hundredths = '0;
      wall_hundredths  = '0;
      replies_due.delete();
    end else begin
      // Compare a reply beat with the oldest prediction
      if (out_valid && !out_stall) begin
        got.kind    = cmrd_kind_t'(out_result_kind);
        got.idx     = out_motor_index;
        got.status  = out_motor_status;
        got.speed   = out_motor_speed;
        got.current = out_motor_current;
        got.ready   = out_ready_mask;
        got.cabin   = out_cabin_temp;
        got.wall    = out_wall_temp;
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reply beat with nothing outstanding: kind %0d motor %0d",
                     $realtime, got.kind, got.idx);
        end else begin
          want = replies_due.pop_front();
          case (want.kind)
            KIND_IGNORED: n_ignored++;
            KIND_TEMP:    n_temp++;
            KIND_STATUS:  n_status++;
            default:      n_data++;
          endcase
          if (got.kind !== want.kind || got.idx !== want.idx || got.status !== want.status ||
              got.speed !== want.speed || got.current !== want.current ||
              got.ready !== want.ready || got.cabin !== want.cabin ||
              got.wall !== want.wall) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: reply mismatch (exp/got): kind %0d/%0d motor %0d/%0d ",
                        "status %0d/%0d speed %0d/%0d current %0d/%0d ready %h/%h ",
                        "cabin %0d/%0d wall %0d/%0d"}, $realtime,
                       want.kind, got.kind, want.idx, got.idx, want.status, got.status,
                       want.speed, got.speed, want.current, got.current,
                       want.ready, got.ready, want.cabin, got.cabin, want.wall, got.wall);
          end
        end
      end
      // Predict the reply for a frame beat
      if (in_valid && !in_stall)
        replies_due.push_back(decode_reply(in_frame_len, in_can_id, in_byte0, in_byte3,
                                           in_byte4, in_byte5, in_byte6, in_byte7));
    end
    pending = replies_due.size();
  end

  initial begin
    mismatches = 0;
    pending    = 0;
    n_ignored  = 0;
    n_temp     = 0;
    n_status   = 0;
    n_data     = 0;
  end

endmodule

### tb/motor_can_reply_decoder_test.sv
// Top of the motor CAN reply decoder testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 100ps

module motor_can_reply_decoder_test;
  import cmrd_pkg::*;

  localparam int MOTORS       = DEF_NUM_MOTORS;
  localparam int PHASE_FRAMES = 250;
  localparam int HOLD_CYCLES  = 80;
  localparam int QUIET_LIMIT  = 3000;

  typedef struct packed {
    logic [3:0]      len;
    logic [10:0]     id;
    logic [7:0][7:0] bytes;
  } frame_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_frame_len;
  logic [10:0]        in_can_id;
  logic [7:0]         in_byte0;
  logic [7:0]         in_byte1;
  logic [7:0]         in_byte2;
  logic [7:0]         in_byte3;
  logic [7:0]         in_byte4;
  logic [7:0]         in_byte5;
  logic [7:0]         in_byte6;
  logic [7:0]         in_byte7;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_result_kind;
  logic [2:0]         out_motor_index;
  logic signed [2:0]  out_motor_status;
  logic signed [15:0] out_motor_speed;
  logic signed [15:0] out_motor_current;
  logic [7:0]         out_ready_mask;
  logic [14:0]        out_cabin_temp;
  logic [14:0]        out_wall_temp;

  int mismatches;
  int pending;
  int n_ignored;
  int n_temp;
  int n_status;
  int n_data;

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   frames_sent = 0;
  int   quiet_cycles = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;

  motor_can_reply_decoder #(.NUM_MOTORS(MOTORS)) i_dut (.*);

  motor_can_reply_decoder_check #(.NUM_MOTORS(MOTORS)) i_check (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one frame beat, with random gaps ahead of it, and hold it until taken
  task automatic offer_frame(input frame_t f);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_frame_len <= f.len;
    in_can_id    <= f.id;
    in_byte0     <= f.bytes[0];
    in_byte1     <= f.bytes[1];
    in_byte2     <= f.bytes[2];
    in_byte3     <= f.bytes[3];
    in_byte4     <= f.bytes[4];
    in_byte5     <= f.bytes[5];
    in_byte6     <= f.bytes[6];
    in_byte7     <= f.bytes[7];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frames_sent++;
  endtask

  // Build a frame from its decoded fields; unused bytes get noise
  function automatic frame_t make_frame(input logic [3:0] len, input logic [10:0] id,
                                        input logic [7:0] lead, input logic [7:0] sub,
                                        input logic [15:0] w45, input logic [15:0] w67);
    frame_t f;
    f.len        = len;
    f.id         = id;
    f.bytes[0]   = lead;
    f.bytes[1]   = 8'($urandom);
    f.bytes[2]   = 8'($urandom);
    f.bytes[3]   = sub;
    f.bytes[5:4] = w45;
    f.bytes[7:6] = w67;
    return f;
  endfunction

  // Mostly well-formed replies with random content, the rest noise and near misses
  function automatic frame_t random_frame();
    frame_t f;
    int     pick;
    f.len   = FRAME_LEN_FULL;
    f.bytes = {$urandom, $urandom};
    pick    = $urandom_range(99);
    if (pick < 72) begin
      if ($urandom_range(9) == 0) begin
        f.id = ID_TEMP;
      end else begin
        f.id = ID_MOTOR_BASE + 11'($urandom_range(MOTORS - 1));
        case ($urandom_range(9))
          0, 1, 2, 3, 4: f.bytes[0] = LEAD_STATUS;
          9:             ;
          default:       f.bytes[0] = LEAD_DATA;
        endcase
        case ($urandom_range(4))
          0:       f.bytes[4] = ST_FAULT_CODE;
          1:       f.bytes[4] = ST_STOP_CODE;
          2:       f.bytes[4] = ST_START_CODE;
          3:       f.bytes[4] = ST_ENABLE_CODE;
          default: ;
        endcase
        case ($urandom_range(7))
          0, 1:    f.bytes[3] = SUB_ACK;
          2, 3:    f.bytes[3] = SUB_FWD;
          4, 5:    f.bytes[3] = SUB_REV;
          default: ;
        endcase
        // Speed extremes now and then
        case ($urandom_range(11))
          0:       f.bytes[5:4] = 16'h8000;
          1:       f.bytes[5:4] = 16'h7FFF;
          2:       f.bytes[5:4] = 16'hFFFF;
          3:       f.bytes[5:4] = 16'h0000;
          default: ;
        endcase
      end
    end else if (pick < 88) begin
      f.len      = 4'($urandom_range(15));
      f.id       = ID_MOTOR_BASE - 11'd2 + 11'($urandom_range(12));
      f.bytes[0] = $urandom_range(1) ? LEAD_DATA : LEAD_STATUS;
    end else begin
      f.len = 4'($urandom);
      f.id  = 11'($urandom);
    end
    return f;
  endfunction

  // Reply side: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
               QUIET_LIMIT, pending);
      $display("motor_can_reply_decoder verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [10:0] mb;
    in_valid     = 1'b0;
    in_frame_len = '0;
    in_can_id    = '0;
    in_byte0     = '0;
    in_byte1     = '0;
    in_byte2     = '0;
    in_byte3     = '0;
    in_byte4     = '0;
    in_byte5     = '0;
    in_byte6     = '0;
    in_byte7     = '0;
    rst_n        = 1'b0;
    mb           = ID_MOTOR_BASE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Temperature: zero, all-ones nibbles, mixed digits
    offer_frame(make_frame(FRAME_LEN_FULL, ID_TEMP, 8'h00, 8'h00, 16'h0000, 16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, ID_TEMP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    offer_frame(make_frame(FRAME_LEN_FULL, ID_TEMP, LEAD_DATA, SUB_FWD, 16'h1234, 16'h9876));
    // Status replies: every code, an unknown code, edge motors
    offer_frame(make_frame(FRAME_LEN_FULL, mb, LEAD_STATUS, 8'h00,
                           {8'h00, ST_FAULT_CODE}, 16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd7, LEAD_STATUS, 8'h00,
                           {8'h00, ST_START_CODE}, 16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd3, LEAD_STATUS, 8'h00,
                           {8'h00, ST_ENABLE_CODE}, 16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, mb, LEAD_STATUS, 8'h00,
                           {8'h00, ST_STOP_CODE}, 16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd5, LEAD_STATUS, 8'h00, 16'h0055,
                           16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd7, LEAD_STATUS, 8'hFF,
                           {8'hFF, ST_FAULT_CODE}, 16'hFFFF));
    // Data replies: ack, forward/reverse extremes, reverse of -32768, other subcodes
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd2, LEAD_DATA, SUB_ACK, 16'h1111,
                           16'h2222));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd1, LEAD_DATA, SUB_FWD, 16'h7FFF,
                           16'h8000));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd1, LEAD_DATA, SUB_REV, 16'h8000,
                           16'h7FFF));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd6, LEAD_DATA, SUB_REV, 16'h0001,
                           16'hFFFF));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd4, LEAD_DATA, SUB_FWD, 16'hFFFF,
                           16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd5, LEAD_DATA, SUB_REV, 16'h0000,
                           16'h0001));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd4, LEAD_DATA, 8'h04, 16'h1234,
                           16'h5678));
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd4, LEAD_DATA, 8'hFF, 16'h4321,
                           16'h8765));
    // Unknown lead byte, bad lengths, identifiers outside the motor range
    offer_frame(make_frame(FRAME_LEN_FULL, mb + 11'd3, 8'h00, SUB_FWD, 16'h0102, 16'h0304));
    offer_frame(make_frame(4'd0, ID_TEMP, 8'h00, 8'h00, 16'h9999, 16'h9999));
    offer_frame(make_frame(4'd15, mb + 11'd1, LEAD_DATA, SUB_FWD, 16'h0505, 16'h0606));
    offer_frame(make_frame(4'd7, mb, LEAD_STATUS, 8'h00, {8'h00, ST_FAULT_CODE}, 16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, mb - 11'd1, LEAD_DATA, SUB_FWD, 16'h0A0A,
                           16'h0B0B));
    offer_frame(make_frame(FRAME_LEN_FULL, ID_TEMP + 11'd1, LEAD_DATA, SUB_FWD, 16'h0C0C,
                           16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, 11'h000, LEAD_STATUS, 8'h00, 16'h000F,
                           16'h0000));
    offer_frame(make_frame(FRAME_LEN_FULL, 11'h7FF, LEAD_DATA, SUB_ACK, 16'hFFFF,
                           16'hFFFF));

    // Random frames over four idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 52; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 52; end
        default: begin tx_idle_pct = 31; rx_idle_pct = 31; end
      endcase
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        // Back up the reply side while frames keep coming
        if (ph == 0 && n == 60) hold_go = 1'b1;
        offer_frame(random_frame());
      end
    end
    in_valid <= 1'b0;

    // Let the last beat register with the checker, drain, then allow the latency to pass
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d frames (25 directed), four idle/stall mixes and one long output hold-off",
             frames_sent);
    $display("Replies checked: %0d ignored, %0d temperature, %0d status, %0d data",
             n_ignored, n_temp, n_status, n_data);
    if (mismatches == 0 && pending == 0) begin
      $display("motor_can_reply_decoder verification clean");
    end else begin
      $display("motor_can_reply_decoder verification failed");
    end
    $finish;
  end

endmodule
